// ===== rtl/length_framed_packet_deframer_core_defines.svh =====
// Assertion macros for the length framed packet deframer.
// Needs clk and rst in the scope of the module that uses them.
`ifndef LENGTH_FRAMED_PACKET_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_FRAMED_PACKET_DEFRAMER_CORE_DEFINES_SVH

// implication checked every clock edge outside reset
`define LFPD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lfpd assertion failed");

// implication checked every clock edge, during reset too
`define LFPD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("lfpd assertion failed");

`endif

// ===== rtl/lfpd_pkg.sv =====
// Shared types, register codes and small helper functions for the deframer.
// No dependencies.
`default_nettype none
package lfpd_pkg;

  localparam int unsigned MaxMarkerBytes = 8;
  localparam int unsigned AddrWidth      = 6;

  typedef enum logic [2:0] {
    REG_HEADER_PATTERN  = 3'd0,
    REG_HEADER_LENGTH   = 3'd1,
    REG_TRAILER_PATTERN = 3'd2,
    REG_TRAILER_LENGTH  = 3'd3,
    REG_SIZE_OFFSET     = 3'd4,
    REG_SIZE_FORMAT     = 3'd5,
    REG_EXTRA_LENGTH    = 3'd6,
    REG_HEX_PAIR_MODE   = 3'd7
  } reg_index_t;

  localparam logic [1:0] StatusGood       = 2'd0;
  localparam logic [1:0] StatusTrailerBad = 2'd1;
  localparam logic [1:0] StatusTooShort   = 2'd2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } result_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) d = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) d = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) d = 4'(c - 8'h57);
    return d;
  endfunction

  function automatic logic [3:0] clamp_len(input logic [3:0] n);
    return (n > 4'(MaxMarkerBytes)) ? 4'(MaxMarkerBytes) : n;
  endfunction

  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lfpd_out_fifo.sv =====
// Two-entry result queue between the deframer engine and the output channel.
// Uses lfpd_pkg for the result type.
`default_nettype none
module lfpd_out_fifo
  import lfpd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output result_t head,
  output logic    nonempty,
  output logic    full
);

  result_t    slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  assign head     = slots[rd_ptr];
  assign nonempty = (count != 2'd0);
  assign full     = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/length_framed_packet_deframer_core.sv =====
// Length framed packet deframer, top level.
// Uses lfpd_pkg, lfpd_out_fifo and the assertion macros header.
//
// Usage:
//  in_valid/in_stall carries one received byte (or one ASCII hex char in
//  hex pair mode) per request. out_valid/out_stall carries frame bytes with
//  out_last and out_status on the final byte of each frame.
//  Registers sit on an APB-style port at byte address 8*index, 64-bit data.
//  Write them only while the block is idle.
//  A frame byte is registered in the result queue before it shows at the output.
//  Throughput: one input request per cycle while in_stall is low. The request
//  that completes a header is taken, then the header bytes are replayed through
//  the frame logic one per cycle while the result queue has room, and input
//  stalls until the replay is done.
//  A two-entry result queue decouples the sides: input keeps flowing while
//  one result waits, and stalls once the queue is full.
//  Reset (synchronous, rst high) restores register defaults, empties the
//  queue and returns to hunting with an empty header window.
`default_nettype none
`include "length_framed_packet_deframer_core_defines.svh"
module length_framed_packet_deframer_core
  import lfpd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic [1:0]           out_status,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [63:0]          pwdata,
  output logic [63:0]          prdata,
  output logic                 pready
);

  // ---------------- configuration registers ----------------
  logic [63:0] header_pattern;
  logic [3:0]  header_length;
  logic [63:0] trailer_pattern;
  logic [3:0]  trailer_length;
  logic [7:0]  size_offset;
  logic [3:0]  size_format;
  logic [15:0] extra_length;
  logic        hex_pair_mode;

  reg_index_t  reg_sel;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_t'(paddr[AddrWidth-1:3]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pattern  <= '0;
      header_length   <= 4'd7;
      trailer_pattern <= '0;
      trailer_length  <= 4'd5;
      size_offset     <= 8'd7;
      size_format     <= 4'd13;
      extra_length    <= '0;
      hex_pair_mode   <= 1'b1;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_HEADER_PATTERN:  header_pattern  <= pwdata;
        REG_HEADER_LENGTH:   header_length   <= pwdata[3:0];
        REG_TRAILER_PATTERN: trailer_pattern <= pwdata;
        REG_TRAILER_LENGTH:  trailer_length  <= pwdata[3:0];
        REG_SIZE_OFFSET:     size_offset     <= pwdata[7:0];
        REG_SIZE_FORMAT:     size_format     <= pwdata[3:0];
        REG_EXTRA_LENGTH:    extra_length    <= pwdata[15:0];
        REG_HEX_PAIR_MODE:   hex_pair_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HEADER_PATTERN:  prdata = header_pattern;
      REG_HEADER_LENGTH:   prdata = {60'd0, header_length};
      REG_TRAILER_PATTERN: prdata = trailer_pattern;
      REG_TRAILER_LENGTH:  prdata = {60'd0, trailer_length};
      REG_SIZE_OFFSET:     prdata = {56'd0, size_offset};
      REG_SIZE_FORMAT:     prdata = {60'd0, size_format};
      REG_EXTRA_LENGTH:    prdata = {48'd0, extra_length};
      REG_HEX_PAIR_MODE:   prdata = {63'd0, hex_pair_mode};
      default:             prdata = '0;
    endcase
  end

  // ---------------- deframer state ----------------
  logic [63:0] hunt_window,        hunt_window_next;
  logic [3:0]  hunt_fill,          hunt_fill_next;
  logic [63:0] trailer_window,     trailer_window_next;
  logic        in_frame,           in_frame_next;
  logic [33:0] frame_position,     frame_position_next;
  logic [31:0] length_accumulator, length_accumulator_next;
  logic [33:0] frame_total,        frame_total_next;
  logic        early_trailer_seen, early_trailer_seen_next;
  logic [3:0]  hex_high_nibble,    hex_high_nibble_next;
  logic        hex_phase,          hex_phase_next;
  // header replay: captured header and bytes still to replay
  logic [63:0] replay_window,      replay_window_next;
  logic [3:0]  replay_count,       replay_count_next;

  logic    q_full, q_nonempty, q_push, q_pop;
  result_t q_head, res;

  logic       replay_active;
  logic       in_acc;
  logic       byte_ok;
  logic [7:0] dec_byte;
  logic       fb_go;
  logic [7:0] fb_byte;
  logic       hunt_match;

  logic [3:0]  hl, tl;
  logic [2:0]  n_bytes;
  logic [8:0]  field_end;
  logic [33:0] fp_new;
  logic [31:0] acc_new;
  logic [1:0]  k;
  logic        match, last;
  logic [1:0]  status;
  logic [63:0] tw_new;
  logic [63:0] hw_shift;
  logic [2:0]  replay_idx;

  assign replay_active = (replay_count != 4'd0);
  assign in_stall      = replay_active | q_full;
  assign in_acc        = in_valid & ~in_stall;
  assign replay_idx    = 3'(replay_count - 4'd1);

  assign hl      = clamp_len(header_length);
  assign tl      = clamp_len(trailer_length);
  assign n_bytes = 3'({1'b0, size_format[1:0]} + 3'd1);
  assign field_end = {1'b0, size_offset} + 9'(n_bytes);

  // hex pair decoding; in hex pair mode a byte exists only on the low-nibble character
  always_comb begin
    hex_high_nibble_next = hex_high_nibble;
    hex_phase_next       = hex_phase;
    byte_ok              = 1'b0;
    dec_byte             = in_byte;
    if (in_acc) begin
      if (hex_pair_mode) begin
        if (!hex_phase) begin
          hex_high_nibble_next = hex_digit(in_byte);
          hex_phase_next       = 1'b1;
        end else begin
          hex_phase_next = 1'b0;
          byte_ok        = 1'b1;
          dec_byte       = {hex_high_nibble, hex_digit(in_byte)};
        end
      end else begin
        hex_phase_next = 1'b0;
        byte_ok        = 1'b1;
      end
    end
  end

  // one frame byte per cycle while the result queue is not full, from the input or from the header replay
  assign fb_go   = replay_active ? ~q_full : (byte_ok & in_frame);
  assign fb_byte = replay_active ? replay_window[8*replay_idx +: 8] : dec_byte;

  always_comb begin
    tw_new = {trailer_window[55:0], fb_byte};
    fp_new = frame_position + 34'd1;
    k      = 2'(fp_new[1:0] - 2'd1 - size_offset[1:0]);
    acc_new = length_accumulator;
    if (size_format[2]) acc_new = {length_accumulator[23:0], fb_byte};
    else                acc_new = length_accumulator | (32'(fb_byte) << {k, 3'b000});
    match = (tl != 4'd0) && (fp_new >= 34'(tl)) &&
            (((tw_new ^ trailer_pattern) & byte_mask(tl)) == 64'd0);
  end

  assign hw_shift   = {hunt_window[55:0], dec_byte};
  assign hunt_match = byte_ok & ~in_frame & (hl != 4'd0) &
                      (size_offset >= {4'd0, hl}) &
                      (((hunt_fill == 4'd8) ? 4'd8 : hunt_fill + 4'd1) >= hl) &
                      (((hw_shift ^ header_pattern) & byte_mask(hl)) == 64'd0);

  always_comb begin
    hunt_window_next        = hunt_window;
    hunt_fill_next          = hunt_fill;
    trailer_window_next     = trailer_window;
    in_frame_next           = in_frame;
    frame_position_next     = frame_position;
    length_accumulator_next = length_accumulator;
    frame_total_next        = frame_total;
    early_trailer_seen_next = early_trailer_seen;
    replay_window_next      = replay_window;
    replay_count_next       = replay_count;
    last                    = 1'b0;
    status                  = StatusGood;

    if (fb_go) begin
      trailer_window_next = tw_new;
      frame_position_next = fp_new;
      if (fp_new > 34'(size_offset) && fp_new <= 34'(field_end)) begin
        length_accumulator_next = acc_new;
        if (fp_new == 34'(field_end)) begin
          if (size_format[3])
            frame_total_next = 34'(acc_new) + 34'(hl) + 34'(tl) + 34'(n_bytes)
                               + 34'(extra_length);
          else
            frame_total_next = 34'(acc_new);
        end
      end
      if (fp_new >= 34'(field_end)) begin
        if (fp_new > frame_total_next) begin
          last   = 1'b1;
          status = StatusTooShort;
        end else if (fp_new == frame_total_next) begin
          last   = 1'b1;
          status = (tl == 4'd0 || (match && !early_trailer_seen)) ?
                   StatusGood : StatusTrailerBad;
        end
      end
      if (!last && match) early_trailer_seen_next = 1'b1;
      if (last) begin
        in_frame_next    = 1'b0;
        hunt_window_next = '0;
        hunt_fill_next   = '0;
      end
      if (replay_active) replay_count_next = replay_count - 4'd1;
    end else if (byte_ok && !in_frame && hl != 4'd0 &&
                 size_offset >= {4'd0, hl}) begin
      // hunting: shift the byte in and look for the header
      hunt_window_next = hw_shift;
      if (hunt_fill != 4'd8) hunt_fill_next = hunt_fill + 4'd1;
      if (hunt_match) begin
        in_frame_next           = 1'b1;
        frame_position_next     = '0;
        length_accumulator_next = '0;
        frame_total_next        = '0;
        early_trailer_seen_next = 1'b0;
        trailer_window_next     = '0;
        replay_window_next      = hw_shift;
        replay_count_next       = hl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_window        <= '0;
      hunt_fill          <= '0;
      trailer_window     <= '0;
      in_frame           <= 1'b0;
      frame_position     <= '0;
      length_accumulator <= '0;
      frame_total        <= '0;
      early_trailer_seen <= 1'b0;
      hex_high_nibble    <= '0;
      hex_phase          <= 1'b0;
      replay_count       <= '0;
    end else begin
      hunt_window        <= hunt_window_next;
      hunt_fill          <= hunt_fill_next;
      trailer_window     <= trailer_window_next;
      in_frame           <= in_frame_next;
      frame_position     <= frame_position_next;
      length_accumulator <= length_accumulator_next;
      frame_total        <= frame_total_next;
      early_trailer_seen <= early_trailer_seen_next;
      hex_high_nibble    <= hex_high_nibble_next;
      hex_phase          <= hex_phase_next;
      replay_count       <= replay_count_next;
    end
  end

  // replay data needs no reset
  always_ff @(posedge clk) begin
    replay_window <= replay_window_next;
  end

  // ---------------- result queue ----------------
  assign res.data   = fb_byte;
  assign res.last   = last;
  assign res.status = status;
  assign q_push     = fb_go;
  assign q_pop      = q_nonempty & ~out_stall;

  lfpd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (res),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty),
    .full      (q_full)
  );

  assign out_valid  = q_nonempty;
  assign out_byte   = q_head.data;
  assign out_last   = q_head.last;
  assign out_status = q_head.status;

  // ---------------- assertions ----------------
  `LFPD_ASSERT(a_replay_blocks_input, replay_active |-> in_stall)
  `LFPD_ASSERT(a_match_starts_replay, hunt_match |=> (replay_active && in_frame))
  `LFPD_ASSERT(a_status_only_on_last, (out_valid && !out_last) |-> (out_status == StatusGood))
  `LFPD_ASSERT_ALWAYS(a_no_push_when_full, q_full |-> !q_push || q_pop)

endmodule
`default_nettype wire
